// File: rtl/fourier_phase_ramp_shift_top_assert.svh
// assertion macros shared by the phase ramp shifter modules
`ifndef FOURIER_PHASE_RAMP_SHIFT_TOP_ASSERT_SVH
`define FOURIER_PHASE_RAMP_SHIFT_TOP_ASSERT_SVH

// same-cycle implication, checked out of reset
`define FPRS_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("fprs assertion failed");

// implication with a fixed delay in cycles
`define FPRS_ASSERT_DELAY(name, ante, dly, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> ##(dly) (cons)) \
    else $error("fprs delayed assertion failed");

`endif

// File: rtl/fprs_pkg.sv
// shared types, constants and coefficient tables of the fourier phase ramp shifter
`timescale 1ns / 1ps

package fprs_pkg;

  localparam int SAMPLE_WIDTH    = 32;
  localparam int COORD_WIDTH     = 12;
  localparam int PHASE_WIDTH_DEF = 32;
  localparam int TRIG_WIDTH_DEF  = 18;

  localparam int STEP_W  = 32;  // phase steps and the phase word, turns * 2^32
  localparam int COUNT_W = 13;  // row and plane counts
  localparam int KW_W    = ((COORD_WIDTH > COUNT_W) ? COORD_WIDTH : COUNT_W) + 1;

  // q30 datapath of the series evaluation
  localparam int Q_W     = 30;
  localparam int T_W     = Q_W + 1;
  localparam int RECIP_W = 31;
  localparam logic [T_W-1:0] Q30_ONE     = T_W'(1) << Q_W;
  localparam logic [30:0]    HALF_PI_Q30 = 31'd1686629713;

  localparam int N_CELLS      = 4;
  localparam int PHASE_STAGES = 5;
  localparam int CELL_STAGES  = 2;
  localparam int ROT_STAGES   = 5;
  localparam int LATENCY      = PHASE_STAGES + N_CELLS * CELL_STAGES + ROT_STAGES;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_X_STEP = 3'd0,
    CFG_Y_STEP = 3'd1,
    CFG_Z_STEP = 3'd2,
    CFG_ROWS   = 3'd3,
    CFG_PLANES = 3'd4
  } cfg_idx_e;

  typedef enum logic [1:0] {
    QUAD_0 = 2'd0,
    QUAD_1 = 2'd1,
    QUAD_2 = 2'd2,
    QUAD_3 = 2'd3
  } quad_e;

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] sample_re;
    logic signed [SAMPLE_WIDTH-1:0] sample_im;
    logic        [COORD_WIDTH-1:0]  column;
    logic        [COORD_WIDTH-1:0]  row;
    logic        [COORD_WIDTH-1:0]  plane;
  } item_t;

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] shifted_re;
    logic signed [SAMPLE_WIDTH-1:0] shifted_im;
  } result_t;

  typedef struct packed {
    logic signed [STEP_W-1:0]  x_step;
    logic signed [STEP_W-1:0]  y_step;
    logic signed [STEP_W-1:0]  z_step;
    logic        [COUNT_W-1:0] rows;
    logic        [COUNT_W-1:0] planes;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    x_step: '0,
    y_step: '0,
    z_step: '0,
    rows:   COUNT_W'(1),
    planes: COUNT_W'(1)
  };

  // data handed from cell to cell
  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] re;
    logic signed [SAMPLE_WIDTH-1:0] im;
    quad_e                          quad;
    logic                           fold;
    logic        [Q_W-1:0]          x;
    logic        [Q_W-1:0]          x2;
    logic        [T_W-1:0]          t_sin;
    logic        [T_W-1:0]          t_cos;
  } horner_t;

  // floor(v / d) = (v * m) >> s, exact for any 30-bit v
  // sine divisors 72, 42, 20, 6
  function automatic logic [RECIP_W-1:0] sin_recip(input int idx);
    logic [RECIP_W-1:0] m;
    case (idx)
      0:       m = 31'd1908874354;
      1:       m = 31'd1636178018;
      2:       m = 31'd1717986919;
      3:       m = 31'd1431655766;
      default: m = '0;
    endcase
    return m;
  endfunction

  function automatic int sin_shift(input int idx);
    int s;
    case (idx)
      0:       s = 37;
      1:       s = 36;
      2:       s = 35;
      3:       s = 33;
      default: s = 0;
    endcase
    return s;
  endfunction

  // cosine divisors 56, 30, 12, 2
  function automatic logic [RECIP_W-1:0] cos_recip(input int idx);
    logic [RECIP_W-1:0] m;
    case (idx)
      0:       m = 31'd1227133514;
      1:       m = 31'd1145324613;
      2:       m = 31'd1431655766;
      3:       m = 31'd1073741824;
      default: m = '0;
    endcase
    return m;
  endfunction

  function automatic int cos_shift(input int idx);
    int s;
    case (idx)
      0:       s = 36;
      1:       s = 35;
      2:       s = 34;
      3:       s = 31;
      default: s = 0;
    endcase
    return s;
  endfunction

endpackage

// File: rtl/fprs_phase.sv
// phase front end: frequency wrap, phase sum, octant fold and q30 angle
`timescale 1ns / 1ps

module fprs_phase #(
  parameter int PHASE_WIDTH = fprs_pkg::PHASE_WIDTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  fprs_pkg::item_t   item_i,
  input  fprs_pkg::cfg_t    cfg_i,
  output logic              valid_o,
  output fprs_pkg::horner_t bus_o
);
  import fprs_pkg::*;

  localparam int DROP = (PHASE_WIDTH < STEP_W) ? STEP_W - PHASE_WIDTH : 0;
  localparam logic [STEP_W-1:0] PHASE_MASK = ~((STEP_W'(1) << DROP) - STEP_W'(1));

  function automatic logic signed [KW_W-1:0] wrap_coord(
    input logic [COORD_WIDTH-1:0] idx,
    input logic [COUNT_W-1:0]     cnt
  );
    logic [KW_W-1:0] i_w;
    logic [KW_W-1:0] c_w;
    i_w = KW_W'(idx);
    c_w = KW_W'(cnt);
    return (i_w > (c_w >> 1)) ? $signed(i_w - c_w) : $signed(i_w);
  endfunction

  logic [PHASE_STAGES-1:0] vld_q;

  // stage 1
  logic signed [SAMPLE_WIDTH-1:0] s1_re_q, s1_im_q;
  logic        [COORD_WIDTH-1:0]  s1_kx_q;
  logic signed [KW_W-1:0]         s1_ky_q, s1_kz_q;
  // stage 2
  logic signed [SAMPLE_WIDTH-1:0] s2_re_q, s2_im_q;
  logic        [STEP_W-1:0]       s2_px_q, s2_py_q, s2_pz_q;
  logic signed [STEP_W+KW_W-1:0]  mul_x, mul_y, mul_z;
  // stage 3
  logic signed [SAMPLE_WIDTH-1:0] s3_re_q, s3_im_q;
  quad_e                          s3_quad_q;
  logic                           s3_fold_q;
  logic        [Q_W-1:0]          s3_rr_q;
  logic        [STEP_W-1:0]       turn;
  logic                           fold_d;
  logic        [T_W-1:0]          rr_full;
  // stage 4
  logic signed [SAMPLE_WIDTH-1:0] s4_re_q, s4_im_q;
  quad_e                          s4_quad_q;
  logic                           s4_fold_q;
  logic        [Q_W-1:0]          s4_x_q;
  logic        [Q_W+31-1:0]       x_prod;
  // stage 5
  horner_t                        s5_q;
  logic        [2*Q_W-1:0]        x2_prod;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[PHASE_STAGES-2:0], valid_i};
    end
  end

  always_comb begin
    mul_x   = (STEP_W+KW_W)'(cfg_i.x_step) * (STEP_W+KW_W)'($signed({1'b0, s1_kx_q}));
    mul_y   = (STEP_W+KW_W)'(cfg_i.y_step) * (STEP_W+KW_W)'(s1_ky_q);
    mul_z   = (STEP_W+KW_W)'(cfg_i.z_step) * (STEP_W+KW_W)'(s1_kz_q);
    // wraps modulo one turn, low bits dropped to the phase resolution
    turn    = (s2_px_q + s2_py_q + s2_pz_q) & PHASE_MASK;
    fold_d  = turn[Q_W-1];
    rr_full = fold_d ? (Q30_ONE - T_W'(turn[Q_W-1:0])) : T_W'(turn[Q_W-1:0]);
    x_prod  = (Q_W+31)'(s3_rr_q) * (Q_W+31)'(HALF_PI_Q30);
    x2_prod = (2*Q_W)'(s4_x_q) * (2*Q_W)'(s4_x_q);
  end

  always_ff @(posedge clk_i) begin
    s1_re_q <= item_i.sample_re;
    s1_im_q <= item_i.sample_im;
    s1_kx_q <= item_i.column;
    s1_ky_q <= wrap_coord(item_i.row, cfg_i.rows);
    s1_kz_q <= wrap_coord(item_i.plane, cfg_i.planes);

    s2_re_q <= s1_re_q;
    s2_im_q <= s1_im_q;
    s2_px_q <= mul_x[STEP_W-1:0];
    s2_py_q <= mul_y[STEP_W-1:0];
    s2_pz_q <= mul_z[STEP_W-1:0];

    s3_re_q   <= s2_re_q;
    s3_im_q   <= s2_im_q;
    s3_quad_q <= quad_e'(turn[STEP_W-1:STEP_W-2]);
    s3_fold_q <= fold_d;
    s3_rr_q   <= rr_full[Q_W-1:0];

    s4_re_q   <= s3_re_q;
    s4_im_q   <= s3_im_q;
    s4_quad_q <= s3_quad_q;
    s4_fold_q <= s3_fold_q;
    s4_x_q    <= x_prod[2*Q_W-1:Q_W];

    s5_q.re    <= s4_re_q;
    s5_q.im    <= s4_im_q;
    s5_q.quad  <= s4_quad_q;
    s5_q.fold  <= s4_fold_q;
    s5_q.x     <= s4_x_q;
    s5_q.x2    <= x2_prod[2*Q_W-1:Q_W];
    s5_q.t_sin <= Q30_ONE;
    s5_q.t_cos <= Q30_ONE;
  end

  assign valid_o = vld_q[PHASE_STAGES-1];
  assign bus_o   = s5_q;

endmodule

// File: rtl/fprs_cell.sv
// one horner step of the sine and cosine series: t = 1 - (x2 * t) / d
`timescale 1ns / 1ps
`include "fourier_phase_ramp_shift_top_assert.svh"

module fprs_cell #(
  parameter int CELL_IDX = 0
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  fprs_pkg::horner_t bus_i,
  output logic              valid_o,
  output fprs_pkg::horner_t bus_o
);
  import fprs_pkg::*;

  localparam logic [RECIP_W-1:0] SIN_M = sin_recip(CELL_IDX);
  localparam logic [RECIP_W-1:0] COS_M = cos_recip(CELL_IDX);
  localparam int                 SIN_S = sin_shift(CELL_IDX);
  localparam int                 COS_S = cos_shift(CELL_IDX);

  logic                     mid_valid_q, out_valid_q;
  horner_t                  mid_d, mid_q, out_d, out_q;
  logic [Q_W+T_W-1:0]       sin_prod, cos_prod;
  logic [Q_W+RECIP_W-1:0]   sin_scaled, cos_scaled;

  always_comb begin
    // first half: the truncated q30 product, parked in the t fields
    sin_prod    = (Q_W+T_W)'(bus_i.x2) * (Q_W+T_W)'(bus_i.t_sin);
    cos_prod    = (Q_W+T_W)'(bus_i.x2) * (Q_W+T_W)'(bus_i.t_cos);
    mid_d       = bus_i;
    mid_d.t_sin = T_W'(sin_prod[2*Q_W-1:Q_W]);
    mid_d.t_cos = T_W'(cos_prod[2*Q_W-1:Q_W]);

    // second half: divide by the constant through its reciprocal
    sin_scaled  = (Q_W+RECIP_W)'(mid_q.t_sin[Q_W-1:0]) * (Q_W+RECIP_W)'(SIN_M);
    cos_scaled  = (Q_W+RECIP_W)'(mid_q.t_cos[Q_W-1:0]) * (Q_W+RECIP_W)'(COS_M);
    out_d       = mid_q;
    out_d.t_sin = Q30_ONE - T_W'(sin_scaled >> SIN_S);
    out_d.t_cos = Q30_ONE - T_W'(cos_scaled >> COS_S);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mid_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      mid_valid_q <= valid_i;
      out_valid_q <= mid_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    mid_q <= mid_d;
    out_q <= out_d;
  end

  assign valid_o = out_valid_q;
  assign bus_o   = out_q;

  `FPRS_ASSERT_IMPL(a_terms_in_unit, valid_o, (bus_o.t_sin <= Q30_ONE) && (bus_o.t_cos <= Q30_ONE))

endmodule

// File: rtl/fprs_rotate.sv
// back end: final sine product, quadrant signs, complex multiply, round and clamp
`timescale 1ns / 1ps

module fprs_rotate #(
  parameter int TRIG_WIDTH = fprs_pkg::TRIG_WIDTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  fprs_pkg::horner_t bus_i,
  output logic              valid_o,
  output fprs_pkg::result_t result_o
);
  import fprs_pkg::*;

  localparam int TRIG_FRAC = TRIG_WIDTH - 2;
  localparam int RSH       = Q_W - TRIG_FRAC;
  localparam logic [T_W-1:0] RHALF = T_W'((1 << RSH) >> 1);
  localparam int PW        = SAMPLE_WIDTH + TRIG_WIDTH;
  localparam logic signed [PW+1:0] RND_HALF = (PW+2)'(1) << (TRIG_FRAC - 1);
  localparam logic [SAMPLE_WIDTH-1:0] MAX_POS = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic [SAMPLE_WIDTH-1:0] MAX_NEG = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

  logic [ROT_STAGES-1:0] vld_q;

  // stage 1
  logic signed [SAMPLE_WIDTH-1:0] s1_re_q, s1_im_q;
  quad_e                          s1_quad_q;
  logic                           s1_fold_q;
  logic        [T_W-1:0]          s1_s_q, s1_c_q;
  logic        [Q_W+T_W-1:0]      s_prod;
  // stage 2
  logic signed [SAMPLE_WIDTH-1:0] s2_re_q, s2_im_q;
  logic signed [TRIG_WIDTH-1:0]   s2_cv_q, s2_sv_q;
  logic        [T_W-1:0]          c_sel, s_sel, a_w, b_w;
  logic signed [TRIG_WIDTH-1:0]   pa, pb, cv_d, sv_d;
  // stage 3
  logic signed [PW-1:0]           p_rc_q, p_is_q, p_rs_q, p_ic_q;
  // stage 4
  logic signed [PW:0]             sum_re_q, sum_im_q;
  // stage 5
  result_t                        res_q;
  logic signed [PW+1:0]           rnd_re, rnd_im;
  logic        [SAMPLE_WIDTH-1:0] sat_re, sat_im;

  function automatic logic [SAMPLE_WIDTH-1:0] clamp(input logic signed [PW+1:0] v);
    logic [PW+1-SAMPLE_WIDTH+1:0] top;
    top = v[PW+1:SAMPLE_WIDTH-1];
    if ((&top) || !(|top)) begin
      return v[SAMPLE_WIDTH-1:0];
    end
    return v[PW+1] ? MAX_NEG : MAX_POS;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[ROT_STAGES-2:0], valid_i};
    end
  end

  always_comb begin
    s_prod = (Q_W+T_W)'(bus_i.x) * (Q_W+T_W)'(bus_i.t_sin);

    // past the octant fold sine and cosine trade places
    c_sel = s1_fold_q ? s1_s_q : s1_c_q;
    s_sel = s1_fold_q ? s1_c_q : s1_s_q;
    a_w   = (c_sel + RHALF) >> RSH;
    b_w   = (s_sel + RHALF) >> RSH;
    pa    = TRIG_WIDTH'(a_w);
    pb    = TRIG_WIDTH'(b_w);
    case (s1_quad_q)
      QUAD_0: begin
        cv_d = pa;
        sv_d = pb;
      end
      QUAD_1: begin
        cv_d = -pb;
        sv_d = pa;
      end
      QUAD_2: begin
        cv_d = -pa;
        sv_d = -pb;
      end
      default: begin
        cv_d = pb;
        sv_d = -pa;
      end
    endcase

    rnd_re = ((PW+2)'(sum_re_q) + RND_HALF) >>> TRIG_FRAC;
    rnd_im = ((PW+2)'(sum_im_q) + RND_HALF) >>> TRIG_FRAC;
    sat_re = clamp(rnd_re);
    sat_im = clamp(rnd_im);
  end

  always_ff @(posedge clk_i) begin
    s1_re_q   <= bus_i.re;
    s1_im_q   <= bus_i.im;
    s1_quad_q <= bus_i.quad;
    s1_fold_q <= bus_i.fold;
    s1_s_q    <= s_prod[Q_W+T_W-1:Q_W];
    s1_c_q    <= bus_i.t_cos;

    s2_re_q <= s1_re_q;
    s2_im_q <= s1_im_q;
    s2_cv_q <= cv_d;
    s2_sv_q <= sv_d;

    p_rc_q <= PW'(s2_re_q) * PW'(s2_cv_q);
    p_is_q <= PW'(s2_im_q) * PW'(s2_sv_q);
    p_rs_q <= PW'(s2_re_q) * PW'(s2_sv_q);
    p_ic_q <= PW'(s2_im_q) * PW'(s2_cv_q);

    sum_re_q <= (PW+1)'(p_rc_q) - (PW+1)'(p_is_q);
    sum_im_q <= (PW+1)'(p_rs_q) + (PW+1)'(p_ic_q);

    res_q.shifted_re <= sat_re;
    res_q.shifted_im <= sat_im;
  end

  assign valid_o  = vld_q[ROT_STAGES-1];
  assign result_o = res_q;

endmodule

// File: rtl/fourier_phase_ramp_shift_top.sv
// top level of the fourier phase ramp shifter: config registers and the cell chain
//
//  channel   signals                                   direction  handshake
//  request   start, busy, item_i                       in         start high, busy low
//  result    done_o, result_o                          out        one-cycle strobe
//  config    cfg_we_i, cfg_idx_i, cfg_data_i           in         write on cfg_we_i
//
// one request per clock, every request gives one result through the pipeline
// of 5 phase stages, 4 horner cells of 2 stages each and 5 rotate stages
// the q30 multipliers of the series set the stage boundaries
// reset is asynchronous: config returns to zero steps and one row and plane,
// the valid pipeline empties; no memory and no clearing pass
// busy never rises and results leave on done_o without backpressure
`timescale 1ns / 1ps
`include "fourier_phase_ramp_shift_top_assert.svh"

module fourier_phase_ramp_shift_top #(
  parameter int PHASE_WIDTH = fprs_pkg::PHASE_WIDTH_DEF,
  parameter int TRIG_WIDTH  = fprs_pkg::TRIG_WIDTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // request side
  input  logic                            start,
  output logic                            busy,
  input  fprs_pkg::item_t                 item_i,
  // result side
  output logic                            done_o,
  output fprs_pkg::result_t               result_o,
  // config write port
  input  logic                            cfg_we_i,
  input  logic [fprs_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [fprs_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import fprs_pkg::*;

  cfg_t    cfg_q;
  logic    accept;
  logic    zero_req;
  logic    valid_chain [N_CELLS+1];
  horner_t bus_chain   [N_CELLS+1];

  // fully pipelined, a request is taken on every cycle
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // request carrying an all-zero bin
  assign zero_req = accept && (item_i.sample_re == '0) && (item_i.sample_im == '0);

  // register file, written at once; the feeding side must write only while drained, not enforced here
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_X_STEP: cfg_q.x_step <= cfg_data_i;
        CFG_Y_STEP: cfg_q.y_step <= cfg_data_i;
        CFG_Z_STEP: cfg_q.z_step <= cfg_data_i;
        CFG_ROWS:   cfg_q.rows   <= cfg_data_i[COUNT_W-1:0];
        CFG_PLANES: cfg_q.planes <= cfg_data_i[COUNT_W-1:0];
        default: begin
          // unmapped index, write dropped
        end
      endcase
    end
  end

  // phase sum, fold into the first octant, angle and its square
  fprs_phase #(
    .PHASE_WIDTH (PHASE_WIDTH)
  ) u_phase (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (accept),
    .item_i  (item_i),
    .cfg_i   (cfg_q),
    .valid_o (valid_chain[0]),
    .bus_o   (bus_chain[0])
  );

  // row of horner cells, sine and cosine series advance side by side
  for (genvar g = 0; g < N_CELLS; g++) begin : g_cell
    fprs_cell #(
      .CELL_IDX (g)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (valid_chain[g]),
      .bus_i   (bus_chain[g]),
      .valid_o (valid_chain[g+1]),
      .bus_o   (bus_chain[g+1])
    );
  end

  // trig rounding, quadrant signs and the complex rotation
  fprs_rotate #(
    .TRIG_WIDTH (TRIG_WIDTH)
  ) u_rotate (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (valid_chain[N_CELLS]),
    .bus_i    (bus_chain[N_CELLS]),
    .valid_o  (done_o),
    .result_o (result_o)
  );

  // every request comes out after the fixed latency
  `FPRS_ASSERT_DELAY(a_request_gives_result, accept, LATENCY, done_o)
  // no result without a request behind it
  `FPRS_ASSERT_IMPL(a_result_has_request, done_o, $past(accept, LATENCY))
  // a zero bin stays zero whatever the phase
  `FPRS_ASSERT_DELAY(a_zero_bin_stays_zero, zero_req, LATENCY, result_o == '0)

endmodule
